@@ hw/rtl/swwl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swwl_pkg
// Types and constants shared by the sliding-window weight limiter
// ----------------------------------------------------------------------------
package swwl_pkg;

   localparam int NOW_W      = 40;
   localparam int WEIGHT_W   = 11;
   localparam int WINDOW_W   = 20;
   localparam int MIN_WAIT_W = 16;
   localparam int AGE_W      = WINDOW_W + 1;   // age clipped just above any window
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [WEIGHT_W-1:0]   BUDGET_RESET   = 11'd900;
   localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 20'd60000;
   localparam logic [MIN_WAIT_W-1:0] MIN_WAIT_RESET = 16'd200;

   typedef enum logic [1:0] {
      STATUS_GRANT = 2'd0,
      STATUS_WAIT  = 2'd1,
      STATUS_OVER  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_BUDGET   = 2'd0,
      REG_WINDOW   = 2'd1,
      REG_MIN_WAIT = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_AGE,
      ST_CHECK,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [NOW_W-1:0]    now_ms;
      logic [WEIGHT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [WINDOW_W-1:0] wait_ms;
      logic [WEIGHT_W-1:0] used_weight;
   } rsp_type;

endpackage

@@ hw/rtl/sliding_window_weight_limiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_weight_limiter
// Sliding-window log rate limiter: prunes expired grants, then grants or
// refuses each request against a weight budget
// ----------------------------------------------------------------------------
// sequence: a request is taken in idle, then the oldest log entry is read,
//   aged and checked; expired entries are pruned one at a time, and an empty
//   log goes straight to the decide step, which stalls until the result
//   register is free; no new request is taken until the current one is decided;
//   each pruned entry costs one log ram read, one age subtract and one compare
// reset: log empty, weight sum zero, registers at 900 / 60000 / 200; log ram
//   contents are not cleared, only live entries are ever read
// ----------------------------------------------------------------------------
module sliding_window_weight_limiter #(
   parameter int LOG_DEPTH = 1024,
   parameter int TIME_BITS = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  swwl_pkg::req_type                   req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output swwl_pkg::rsp_type                   rsp_data,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [swwl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [swwl_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [swwl_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import swwl_pkg::*;

   localparam int IDX_W   = $clog2(LOG_DEPTH);
   localparam int CNT_W   = $clog2(LOG_DEPTH + 1);
   localparam int ENTRY_W = TIME_BITS + WEIGHT_W;

   localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(LOG_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_WIDE = (CNT_W + 1)'(LOG_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(LOG_DEPTH - 1);

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic [WEIGHT_W-1:0]   budget_ff,   budget_in;
   logic [WINDOW_W-1:0]   window_ff,   window_in;
   logic [MIN_WAIT_W-1:0] min_wait_ff, min_wait_in;
   logic                  csr_write;
   reg_index_type         csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      budget_in   = budget_ff;
      window_in   = window_ff;
      min_wait_in = min_wait_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_BUDGET:   budget_in   = pwdata[WEIGHT_W-1:0];
            REG_WINDOW:   window_in   = pwdata[WINDOW_W-1:0];
            REG_MIN_WAIT: min_wait_in = pwdata[MIN_WAIT_W-1:0];
            default:      ;   // writes outside the map are dropped
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         REG_BUDGET:   prdata = CSR_DATA_W'(budget_ff);
         REG_WINDOW:   prdata = CSR_DATA_W'(window_ff);
         REG_MIN_WAIT: prdata = CSR_DATA_W'(min_wait_ff);
         default:      prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // sequencer state and datapath registers
   // ------------------------------------------------------------------------
   state_type             state_ff, state_in;

   logic [TIME_BITS-1:0]  now_ff,     now_in;      // trimmed time stamp
   logic [WEIGHT_W-1:0]   weight_ff,  weight_in;
   logic [AGE_W-1:0]      age_ff,     age_in;      // clipped age of oldest entry
   logic [WEIGHT_W-1:0]   ent_wt_ff,  ent_wt_in;   // weight of oldest entry
   logic [IDX_W-1:0]      oldest_ff,  oldest_in;
   logic [CNT_W-1:0]      count_ff,   count_in;
   logic [WEIGHT_W-1:0]   sum_ff,     sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff,  rsp_data_in;

   // time stamp bits beyond the stored width are dropped, narrower stamps zero-extended
   logic [TIME_BITS-1:0]  now_trim;

   generate
      if (TIME_BITS > NOW_W) begin : g_now_wide
         assign now_trim = {{(TIME_BITS - NOW_W){1'b0}}, req_data.now_ms};
      end else if (TIME_BITS == NOW_W) begin : g_now_same
         assign now_trim = req_data.now_ms;
      end else begin : g_now_narrow
         assign now_trim = req_data.now_ms[TIME_BITS-1:0];
      end
   endgenerate

   // ------------------------------------------------------------------------
   // log ram: {time stamp, weight} per entry
   // ------------------------------------------------------------------------
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0]    ram_wr_data;
   logic                  ram_rd_en;
   logic [ENTRY_W-1:0]    ram_rd_data;

   swwl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LOG_DEPTH)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (oldest_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // shared arithmetic
   // ------------------------------------------------------------------------
   logic [TIME_BITS-1:0]  stamp;
   logic [TIME_BITS:0]    age_diff;       // borrow in the top bit
   logic [AGE_W-1:0]      age_clip;
   logic                  log_empty;
   logic                  log_full;
   logic                  expired;
   logic                  over_budget;
   logic [WEIGHT_W:0]     sum_plus;
   logic                  fits;
   logic [WINDOW_W-1:0]   remain;
   logic [WINDOW_W-1:0]   wait_val;
   logic [CNT_W:0]        slot_wide;
   logic [CNT_W:0]        slot_wrap;
   logic [IDX_W-1:0]      oldest_next;
   logic                  out_free;

   assign stamp     = ram_rd_data[ENTRY_W-1:WEIGHT_W];
   assign age_diff  = {1'b0, now_ff} - {1'b0, stamp};

   // time going backwards reads as age zero; large ages saturate
   always_comb begin
      if (age_diff[TIME_BITS]) begin
         age_clip = '0;
      end else if (|age_diff[TIME_BITS-1:AGE_W]) begin
         age_clip = '1;
      end else begin
         age_clip = age_diff[AGE_W-1:0];
      end
   end

   assign log_empty   = (count_ff == '0);
   assign log_full    = (count_ff == DEPTH_CNT);
   assign expired     = (age_ff > {1'b0, window_ff});
   assign over_budget = (weight_ff > budget_ff);
   assign sum_plus    = {1'b0, sum_ff} + {1'b0, weight_ff};
   assign fits        = !log_full && (sum_plus <= {1'b0, budget_ff});

   // suggested wait: window minus age of the oldest entry, floored
   always_comb begin
      if (age_ff < {1'b0, window_ff}) begin
         remain = window_ff - age_ff[WINDOW_W-1:0];
      end else begin
         remain = '0;
      end
      if (remain > WINDOW_W'(min_wait_ff)) begin
         wait_val = remain;
      end else begin
         wait_val = WINDOW_W'(min_wait_ff);
      end
   end

   // next free slot of the ring
   assign slot_wide   = (CNT_W + 1)'(oldest_ff) + (CNT_W + 1)'(count_ff);
   assign slot_wrap   = (slot_wide >= DEPTH_WIDE) ? (slot_wide - DEPTH_WIDE) : slot_wide;
   assign ram_wr_addr = slot_wrap[IDX_W-1:0];
   assign ram_wr_data = {now_ff, weight_ff};

   assign oldest_next = (oldest_ff == LAST_IDX) ? '0 : oldest_ff + 1'b1;

   // result register is free, or its transfer happens this cycle
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = log_empty ? ST_DECIDE : ST_AGE;
         end
         ST_AGE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = expired ? ST_READ : ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // sequencer outputs
   // ------------------------------------------------------------------------
   logic do_accept;
   logic do_pop;
   logic do_decide;

   always_comb begin
      req_ready = 1'b0;
      ram_rd_en = 1'b0;
      do_pop    = 1'b0;
      do_decide = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_READ:   ram_rd_en = !log_empty;
         ST_AGE:    ;
         ST_CHECK:  do_pop    = expired;
         ST_DECIDE: do_decide = out_free;
         default:   ;
      endcase
   end

   assign do_accept = req_valid && req_ready;
   assign ram_wr_en = do_decide && !over_budget && fits;

   // ------------------------------------------------------------------------
   // datapath next values
   // ------------------------------------------------------------------------
   always_comb begin
      now_in       = now_ff;
      weight_in    = weight_ff;
      age_in       = age_ff;
      ent_wt_in    = ent_wt_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (do_accept) begin
         now_in    = now_trim;
         weight_in = req_data.weight;
      end

      // capture oldest entry in the state after its read
      if (state_ff == ST_AGE) begin
         age_in    = age_clip;
         ent_wt_in = ram_rd_data[WEIGHT_W-1:0];
      end

      // drop an expired entry
      if (do_pop) begin
         sum_in    = sum_ff - ent_wt_ff;
         oldest_in = oldest_next;
         count_in  = count_ff - 1'b1;
      end

      if (do_decide) begin
         rsp_valid_in = 1'b1;
         if (over_budget) begin
            rsp_data_in.status      = STATUS_OVER;
            rsp_data_in.wait_ms     = '0;
            rsp_data_in.used_weight = sum_ff;
         end else if (fits) begin
            sum_in                  = sum_plus[WEIGHT_W-1:0];
            count_in                = count_ff + 1'b1;
            rsp_data_in.status      = STATUS_GRANT;
            rsp_data_in.wait_ms     = '0;
            rsp_data_in.used_weight = sum_plus[WEIGHT_W-1:0];
         end else begin
            // log holds at least one entry here, age_ff is the oldest one's
            rsp_data_in.status      = STATUS_WAIT;
            rsp_data_in.wait_ms     = wait_val;
            rsp_data_in.used_weight = sum_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         budget_ff    <= BUDGET_RESET;
         window_ff    <= WINDOW_RESET;
         min_wait_ff  <= MIN_WAIT_RESET;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         budget_ff    <= budget_in;
         window_ff    <= window_in;
         min_wait_ff  <= min_wait_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      weight_ff   <= weight_in;
      age_ff      <= age_in;
      ent_wt_ff   <= ent_wt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/swwl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swwl_ram
// Generic single-port-write, single-port-read RAM with registered read data
// ----------------------------------------------------------------------------
module swwl_ram #(
   parameter int WIDTH = 51,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
